// ===== rtl/ldt_pkg.sv =====
// Shared types and constants for the two-variable linear Diophantine solver.
// Used by the top level; has no dependencies.
package ldt_pkg;

	localparam int COEF_W_DEF = 32;
	localparam int IN_FIELD_W = 32;
	localparam int IN_DATA_W  = 96;
	localparam int GCD_W      = 31;
	localparam int PROD_W     = 64;
	localparam int OUT_DATA_W = 160;

	localparam logic [GCD_W-1:0] GCD_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_FIN,
		ST_CDIV,
		ST_XMUL,
		ST_OUT
	} ldt_state_t;

endpackage

// ===== rtl/ldt_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Stand-alone; the divisor must be nonzero when a division is started.
module ldt_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic [W-1:0]     diff;
	logic             fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial[W-1:0] - dvs_q;
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/ldt_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, modulo 2^PROD_W.
// Stand-alone; the multiplicand may be signed, the multiplier is unsigned.
module ldt_mul #(
	parameter int OP_W   = 32,
	parameter int PROD_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OP_W-1:0]   mplier,
	input  logic [PROD_W-1:0] mcand,
	output logic              busy,
	output logic [PROD_W-1:0] prod
);

	localparam int CNT_W = $clog2(OP_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [OP_W-1:0]   mr_q;
	logic [PROD_W-1:0] md_q;
	logic [PROD_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(OP_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mr_q  <= mplier;
			md_q  <= mcand;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (mr_q[0]) begin
				acc_q <= acc_q + md_q;
			end
			md_q <= {md_q[PROD_W-2:0], 1'b0};
			mr_q <= {1'b0, mr_q[OP_W-1:1]};
		end
	end

	assign busy = cnt_q != '0;
	assign prod = acc_q;

endmodule

// ===== rtl/linear_diophantine_two_var.sv =====
// Two-variable linear Diophantine solver: a*x + b*y = c by extended Euclid.
// Depends on ldt_pkg, ldt_div and ldt_mul.
//
//  channel | dir | payload
//  s_*     | in  | tdata[95:0]: coef_a, coef_b, rhs_value
//  m_*     | out | tuser: solvable; tdata[159:0]: gcd_value, sol_x, sol_y
//
// Each Euclid step runs one division in the serial divider; the Bezout
// updates run in the serial multipliers alongside the next division.
// After the loop the divider checks that the gcd divides rhs_value and the
// multipliers scale the Bezout factors; both coefficients zero go straight to output.
// A new request is taken once the previous result sits in the output register.
// Reset clears the controller and the output valid flag.
module linear_diophantine_two_var #(
	parameter int COEF_WIDTH = ldt_pkg::COEF_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// coef_a [31:0], coef_b [63:32], rhs_value [95:64]
	input  logic [ldt_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// solvable [0]
	output logic                           m_tuser,
	// gcd_value [30:0], sol_x [94:31], sol_y [158:95], zero [159]
	output logic [ldt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ldt_pkg::*;

	localparam int W  = COEF_WIDTH;
	localparam int SW = COEF_WIDTH + 2;

	ldt_state_t state_q, state_d;

	logic [W-1:0]  a_raw, b_raw, c_raw;
	logic [W-1:0]  ma, mb, mc;

	logic [W-1:0]  ra_q, rb_q, mc_q;
	logic          na_q, nb_q, nc_q;
	logic [SW-1:0] sa_q, sb_q, ta_q, tb_q;
	logic          pend_q;
	logic          solv_q;
	logic [PROD_W-1:0] x_q, y_q;

	logic          out_valid_q;
	logic          out_solv_q;
	logic [GCD_W-1:0]  out_gcd_q;
	logic [PROD_W-1:0] out_x_q, out_y_q;

	logic          div_start, div_busy;
	logic [W-1:0]  div_n, div_d, div_quo, div_rem;
	logic          mul_start, mul_busy_s, mul_busy_t;
	logic [PROD_W-1:0] mcand_s, mcand_t, prod_s, prod_t;
	logic          mul_busy;

	logic          accept, step_proc, step_upd, fin_go, load_out, st_upd;
	logic [31:0]   g_ext;
	logic [GCD_W-1:0]  gcd_sat;

	assign a_raw = s_tdata[W-1:0];
	assign b_raw = s_tdata[IN_FIELD_W+W-1:IN_FIELD_W];
	assign c_raw = s_tdata[2*IN_FIELD_W+W-1:2*IN_FIELD_W];
	assign ma    = a_raw[W-1] ? W'(0) - a_raw : a_raw;
	assign mb    = b_raw[W-1] ? W'(0) - b_raw : b_raw;
	assign mc    = c_raw[W-1] ? W'(0) - c_raw : c_raw;

	assign mul_busy  = mul_busy_s || mul_busy_t;
	assign accept    = s_tready && s_tvalid;
	assign step_proc = state_q == ST_STEP && !pend_q && !div_busy;
	assign step_upd  = state_q == ST_STEP && pend_q && !mul_busy;
	assign fin_go    = state_q == ST_FIN && !mul_busy;
	assign st_upd    = step_upd || (fin_go && pend_q);
	assign load_out  = state_q == ST_OUT && (!out_valid_q || m_tready);

	assign g_ext   = 32'(ra_q);
	assign gcd_sat = g_ext[31] ? GCD_MAX : g_ext[GCD_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (ma == '0 && mb == '0) begin
						state_d = ST_OUT;
					end else if (mb == '0) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				if (step_proc && div_rem == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				if (!div_busy) begin
					state_d = (div_rem != '0) ? ST_OUT : ST_XMUL;
				end
			end
			ST_XMUL: begin
				if (!mul_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = state_q == ST_IDLE;
		div_start = 1'b0;
		div_n     = ma;
		div_d     = mb;
		mul_start = 1'b0;
		mcand_s   = {{(PROD_W-SW){sb_q[SW-1]}}, sb_q};
		mcand_t   = {{(PROD_W-SW){tb_q[SW-1]}}, tb_q};
		case (state_q)
			ST_IDLE: begin
				div_start = s_tvalid && mb != '0;
			end
			ST_STEP: begin
				div_n     = rb_q;
				div_d     = div_rem;
				div_start = step_proc && div_rem != '0;
				mul_start = step_proc;
			end
			ST_FIN: begin
				div_n     = mc_q;
				div_d     = ra_q;
				div_start = fin_go;
			end
			ST_CDIV: begin
				mcand_s   = {{(PROD_W-SW){sa_q[SW-1]}}, sa_q};
				mcand_t   = {{(PROD_W-SW){ta_q[SW-1]}}, ta_q};
				mul_start = !div_busy && div_rem == '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step_proc) begin
				pend_q <= 1'b1;
			end else if (st_upd) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ra_q   <= ma;
			rb_q   <= mb;
			mc_q   <= mc;
			na_q   <= a_raw[W-1];
			nb_q   <= b_raw[W-1];
			nc_q   <= c_raw[W-1];
			sa_q   <= SW'(1);
			sb_q   <= '0;
			ta_q   <= '0;
			tb_q   <= SW'(1);
			solv_q <= ma == '0 && mb == '0 && mc == '0;
			x_q    <= '0;
			y_q    <= '0;
		end
		if (step_proc) begin
			ra_q <= rb_q;
			rb_q <= div_rem;
		end
		if (st_upd) begin
			sa_q <= sb_q;
			sb_q <= sa_q - prod_s[SW-1:0];
			ta_q <= tb_q;
			tb_q <= ta_q - prod_t[SW-1:0];
		end
		if (state_q == ST_XMUL && !mul_busy) begin
			solv_q <= 1'b1;
			x_q    <= (na_q ^ nc_q) ? PROD_W'(0) - prod_s : prod_s;
			y_q    <= (nb_q ^ nc_q) ? PROD_W'(0) - prod_t : prod_t;
		end
		if (load_out) begin
			out_solv_q <= solv_q;
			out_gcd_q  <= gcd_sat;
			out_x_q    <= x_q;
			out_y_q    <= y_q;
		end
	end

	ldt_div #(
		.W (W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	ldt_mul #(
		.OP_W   (W),
		.PROD_W (PROD_W)
	) u_mul_s (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mplier (div_quo),
		.mcand  (mcand_s),
		.busy   (mul_busy_s),
		.prod   (prod_s)
	);

	ldt_mul #(
		.OP_W   (W),
		.PROD_W (PROD_W)
	) u_mul_t (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mplier (div_quo),
		.mcand  (mcand_t),
		.busy   (mul_busy_t),
		.prod   (prod_t)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_solv_q;
	assign m_tdata  = {1'b0, out_y_q, out_x_q, out_gcd_q};

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier started while busy");
	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_STEP || state_q == ST_FIN))
		else $error("Bezout update pending outside the Euclid loop");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || m_tready))
		else $error("output register overwritten before it was taken");
	a_unsolv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (out_x_q == '0 && out_y_q == '0))
		else $error("unsolvable result carries a nonzero solution");
`endif

endmodule

// ===== tb/sv/diophantine_checker.sv =====
// Checker for the linear Diophantine solver: watches both stream channels, predicts the
// solution of every accepted request and compares it with the result the block returns.
// Depends on ldt_pkg.
module diophantine_checker #(
	parameter int COEF_WIDTH = ldt_pkg::COEF_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ldt_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           m_tuser,
	input  logic [ldt_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                             fail_count,
	output int                             solutions_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ldt_pkg::*;

	typedef struct packed {
		logic               solvable;
		logic [GCD_W-1:0]   gcd;
		logic [PROD_W-1:0]  x;
		logic [PROD_W-1:0]  y;
	} solution_t;

	solution_t expected_solutions[$];

	function automatic void split_coef(input logic [IN_FIELD_W-1:0] raw,
			output logic [63:0] mag, output logic neg);
		logic [63:0] full;
		logic [63:0] v;
		full = 64'd1 << COEF_WIDTH;
		v = {32'd0, raw} & (full - 64'd1);
		neg = v[COEF_WIDTH-1];
		mag = neg ? full - v : v;
	endfunction

	function automatic solution_t solve_diophantine(input logic [IN_DATA_W-1:0] req);
		logic [63:0] mag_a, mag_b, mag_c;
		logic neg_a, neg_b, neg_c;
		logic [63:0] p, q, r, g, cq, ra, rb, sa, sb, ta, tb, quo, tmp;
		solution_t sol;
		split_coef(req[31:0], mag_a, neg_a);
		split_coef(req[63:32], mag_b, neg_b);
		split_coef(req[95:64], mag_c, neg_c);
		p = mag_a;
		q = mag_b;
		while (q != 64'd0) begin
			r = p % q;
			p = q;
			q = r;
		end
		g = p;
		sol.solvable = 1'b0;
		sol.gcd = (g > 64'h7FFF_FFFF) ? GCD_MAX : g[GCD_W-1:0];
		sol.x = '0;
		sol.y = '0;
		if (g == 64'd0) begin
			sol.solvable = (mag_c == 64'd0);
			return sol;
		end
		if (mag_c % g != 64'd0)
			return sol;
		// Bezout factors of the reduced magnitudes; all arithmetic wraps at 64 bits.
		ra = mag_a / g;
		rb = mag_b / g;
		sa = 64'd1;
		sb = 64'd0;
		ta = 64'd0;
		tb = 64'd1;
		while (rb != 64'd0) begin
			quo = ra / rb;
			tmp = rb; rb = ra - quo * rb; ra = tmp;
			tmp = sb; sb = sa - quo * sb; sa = tmp;
			tmp = tb; tb = ta - quo * tb; ta = tmp;
		end
		cq = mag_c / g;
		if (neg_c)
			cq = 64'd0 - cq;
		sol.x = sa * cq;
		sol.y = ta * cq;
		if (neg_a)
			sol.x = 64'd0 - sol.x;
		if (neg_b)
			sol.y = 64'd0 - sol.y;
		sol.solvable = 1'b1;
		return sol;
	endfunction

	task automatic check_field(input string field, input logic signed [PROD_W-1:0] want,
			input logic signed [PROD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		solutions_pending = 0;
	end

	always @(posedge clk) begin
		solution_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_solutions.insert(expected_solutions.size(),
					solve_diophantine(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_solutions.size() == 0) begin
					$error("result returned with no request outstanding");
					fail_count++;
				end else begin
					want = expected_solutions.pop_front();
					check_field("solvable", want.solvable, m_tuser);
					check_field("gcd_value", want.gcd, m_tdata[30:0]);
					check_field("sol_x", $signed(want.x), $signed(m_tdata[94:31]));
					check_field("sol_y", $signed(want.y), $signed(m_tdata[158:95]));
					check_field("tdata padding", 0, m_tdata[159]);
				end
			end
			solutions_pending = expected_solutions.size();
		end
	end

endmodule

// ===== tb/sv/tb_linear_diophantine_two_var.sv =====
// Top of the linear Diophantine solver testbench: clock, reset, request stimulus and
// result back-pressure, with the verdict taken from diophantine_checker.
// Depends on ldt_pkg, linear_diophantine_two_var and diophantine_checker.
module tb_linear_diophantine_two_var;
	timeunit 1ns;
	timeprecision 1ps;

	import ldt_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int HOLD_CYCLES = 6000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  m_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fail_count;
	int                    solutions_pending;
	int                    send_gap_pct;
	int                    recv_stall_pct;
	bit                    hold_req;
	int                    cycle_count;

	linear_diophantine_two_var DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	diophantine_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tuser           (m_tuser),
		.m_tdata           (m_tdata),
		.fail_count        (fail_count),
		.solutions_pending (solutions_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// The receiver counts its own long hold-off once one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_request(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		logic taken;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c, b, a};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_for_solutions();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (solutions_pending != 0);
	endtask

	function automatic logic [31:0] random_sign(input logic [31:0] mag);
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5: return 32'h8000_0001;
			6: return random_sign(32'd1 << $urandom_range(30));
			default: return random_sign(32'h7FFF_FFFF - $urandom_range(3));
		endcase
	endfunction

	task automatic send_random_item();
		logic [31:0] g;
		logic [31:0] lim;
		logic [31:0] a, b, c;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				a = $urandom;
				b = $urandom;
				c = $urandom;
			end
			4, 5, 6, 7: begin
				// Common factor in all three, to exercise the extended Euclid path.
				g = $urandom_range(1, 5000);
				lim = 32'h7FFF_FFFF / g;
				a = random_sign(g * $urandom_range(0, lim));
				b = random_sign(g * $urandom_range(0, lim));
				c = random_sign(g * $urandom_range(0, lim));
			end
			8: begin
				a = $urandom_range(40) - 20;
				b = $urandom_range(40) - 20;
				c = $urandom_range(40) - 20;
			end
			default: begin
				a = edge_value();
				b = edge_value();
				c = edge_value();
			end
		endcase
		send_request(a, b, c);
	endtask

	task automatic run_random(input int count, input int gap_pct, input int stall_pct);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_item();
		wait_for_solutions();
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(32'd0, 32'd0, 32'd0);
		send_request(32'd0, 32'd0, 32'd7);
		send_request(32'd0, 32'd0, 32'h8000_0000);
		send_request(32'd0, 32'd6, 32'd18);
		send_request(32'd6, 32'd0, -32'sd12);
		send_request(32'd4, 32'd6, 32'd7);
		send_request(32'd4, 32'd6, -32'sd10);
		send_request(-32'sd4, 32'd6, 32'd10);
		send_request(32'd4, -32'sd6, 32'd10);
		send_request(-32'sd4, -32'sd6, -32'sd10);
		send_request(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
		send_request(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0001);
		send_request(32'h8000_0000, 32'd3, 32'd1);
		send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_request(32'h8000_0000, 32'd0, 32'd5);
		send_request(32'd0, 32'h8000_0000, 32'd0);
		send_request(32'd1, 32'd1, 32'h7FFF_FFFF);
		send_request(32'd1836311903, 32'd1134903170, -32'sd1);
		send_request(32'd12, 32'd18, 32'h8000_0000);
		send_request(32'd2, 32'd4, 32'h8000_0000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		wait_for_solutions();

		run_random(80, 0, 0);
		run_random(80, 72, 0);
		run_random(80, 0, 72);
		run_random(80, 13, 13);
		// The receiver holds off long enough for the block to stall new requests.
		hold_req = 1'b1;
		run_random(76, 0, 0);

		repeat (2000) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ldt_pkg.sv
rtl/ldt_div.sv
rtl/ldt_mul.sv
rtl/linear_diophantine_two_var.sv
tb/sv/diophantine_checker.sv
tb/sv/tb_linear_diophantine_two_var.sv
